/* rtl/crsc_pkg.sv */
// Shared types and constants for the conveyor ramp and sorter controller.
// Used by crsc_pass and conveyor_ramp_sorter_control; no dependencies.
package crsc_pkg;

    // Fixed field widths.
    localparam int DEB_MS_W   = 10;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int RAMP_W     = 9;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_GREEN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_RIPE   = 2'd3;

    // Register reset values.
    localparam logic [DEB_MS_W-1:0] DEBOUNCE_MS_RST   = 10'd200;
    localparam logic [7:0]          RAMP_INTERVAL_RST = 8'd10;
    localparam logic [7:0]          ANGLE_GREEN_RST   = 8'd110;
    localparam logic [7:0]          ANGLE_RIPE_RST    = 8'd70;

    // Host command bytes (ASCII).
    localparam logic [7:0] CMD_NONE  = 8'h00;
    localparam logic [7:0] CMD_STOP  = 8'h45;  // 'E'
    localparam logic [7:0] CMD_START = 8'h49;  // 'I'
    localparam logic [7:0] CMD_BRAKE = 8'h46;  // 'F'
    localparam logic [7:0] CMD_RIPE  = 8'h4D;  // 'M'
    localparam logic [7:0] CMD_GREEN = 8'h56;  // 'V'

    // Command event codes.
    localparam logic [2:0] CEV_NONE      = 3'd0;
    localparam logic [2:0] CEV_SOFT_STOP = 3'd1;
    localparam logic [2:0] CEV_BLOCKED   = 3'd2;
    localparam logic [2:0] CEV_STARTING  = 3'd3;
    localparam logic [2:0] CEV_BRAKING   = 3'd4;
    localparam logic [2:0] CEV_RIPE      = 3'd5;
    localparam logic [2:0] CEV_GREEN     = 3'd6;

    // Ramp event codes.
    localparam logic [1:0] REV_NONE    = 2'd0;
    localparam logic [1:0] REV_FULL    = 2'd1;
    localparam logic [1:0] REV_STOPPED = 2'd2;

    // Button command codes.
    localparam logic [2:0] BCMD_NONE  = 3'd0;
    localparam logic [2:0] BCMD_START = 3'd1;
    localparam logic [2:0] BCMD_BRAKE = 3'd2;
    localparam logic [2:0] BCMD_RIPE  = 3'd3;
    localparam logic [2:0] BCMD_GREEN = 3'd4;

    // Belt modes, one-hot internally.
    typedef enum logic [3:0] {
        MODE_WAIT  = 4'b0001,
        MODE_ACCEL = 4'b0010,
        MODE_OPER  = 4'b0100,
        MODE_BRAKE = 4'b1000
    } mode_t;

    // Encoded belt mode as reported on the result channel.
    localparam logic [1:0] BELT_WAIT  = 2'd0;
    localparam logic [1:0] BELT_ACCEL = 2'd1;
    localparam logic [1:0] BELT_OPER  = 2'd2;
    localparam logic [1:0] BELT_BRAKE = 2'd3;

    typedef struct packed {
        logic [DEB_MS_W-1:0] debounce_ms;
        logic [7:0]          ramp_interval_ms;
        logic [7:0]          angle_green;
        logic [7:0]          angle_ripe;
    } cfg_t;

    typedef struct packed {
        logic       ms_tick;
        logic       cmd_valid;
        logic [7:0] cmd_byte;
        logic       belt_button;
        logic       fruit_button;
        logic       estop_level;
        logic       estop_fell;
    } in_item_t;

    typedef struct packed {
        mode_t             mode;
        logic              route_ripe;
        logic              prev_belt_level;
        logic              prev_fruit_level;
        logic [RAMP_W-1:0] ramp_elapsed;
    } ctrl_state_t;

    typedef struct packed {
        logic [7:0] servo_angle;
        logic [1:0] belt_mode;
        logic [2:0] command_event;
        logic [1:0] ramp_event;
        logic       estop_handled;
        logic [2:0] button_command;
    } result_t;

    function automatic logic [1:0] mode_code(input mode_t mode);
        logic [1:0] code;
        case (mode)
            MODE_WAIT:  code = BELT_WAIT;
            MODE_ACCEL: code = BELT_ACCEL;
            MODE_OPER:  code = BELT_OPER;
            MODE_BRAKE: code = BELT_BRAKE;
            default:    code = BELT_WAIT;
        endcase
        return code;
    endfunction

endpackage

/* rtl/conveyor_ramp_sorter_control.sv */
// Top level of the conveyor belt ramp and fruit sorter controller.
// Depends on crsc_pkg and crsc_pass.
//
// Usage: each transfer on the input channel (in_valid, in_stall) is one
// control pass: millisecond tick, optional host command byte, the two push
// button levels and the emergency-stop level and edge flag. Each pass gives
// exactly one result transfer on the output channel (out_valid, out_stall)
// with the motor duty, servo angle, belt mode and the events of the pass.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// writes debounce time, ramp interval and the two servo angles; it is
// always ready and should be used only while no pass is in flight.
// An input transfer is first held in the input register, then goes through
// the pass logic into the result register, where the result becomes valid.
// Throughput is one pass per cycle while out_stall is low, set by the
// combinational pass logic; belt state and result load in the same edge.
// Reset clears both stages, puts the belt in waiting with zero duty on the
// green route and restores the register defaults. When the receiver stalls,
// the result register holds; one more pass waits in the input register and
// after that in_stall rises until the result is taken.
module conveyor_ramp_sorter_control
    import crsc_pkg::*;
#(
    parameter int DUTY_BITS     = 8,
    parameter int DEBOUNCE_BITS = 10
) (
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,

    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    ms_tick,
    input  logic                    cmd_valid,
    input  logic [7:0]              cmd_byte,
    input  logic                    belt_button,
    input  logic                    fruit_button,
    input  logic                    estop_level,
    input  logic                    estop_fell,

    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [DUTY_BITS-1:0]    motor_duty,
    output logic [7:0]              servo_angle,
    output logic [1:0]              belt_mode,
    output logic [2:0]              command_event,
    output logic [1:0]              ramp_event,
    output logic                    estop_handled,
    output logic [2:0]              button_command
);

    cfg_t                     cfg_reg;
    logic                     in_valid_reg;
    in_item_t                 in_item_reg;
    logic                     out_valid_reg;
    result_t                  result_reg;
    ctrl_state_t              state_reg;
    logic [DUTY_BITS-1:0]     duty_reg;
    logic [DEBOUNCE_BITS-1:0] deb_reg;

    ctrl_state_t              state_next;
    logic [DUTY_BITS-1:0]     duty_next;
    logic [DEBOUNCE_BITS-1:0] deb_next;
    result_t                  result_next;
    in_item_t                 in_item;
    logic                     advance;
    logic                     in_xfer;
    logic                     pass_fire;

    // The result register can take a new pass when it is empty or being
    // drained this cycle; the input register moves on under the same rule.
    assign advance   = !out_valid_reg || !out_stall;
    assign pass_fire = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign in_xfer   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_item.ms_tick      = ms_tick;
        in_item.cmd_valid    = cmd_valid;
        in_item.cmd_byte     = cmd_byte;
        in_item.belt_button  = belt_button;
        in_item.fruit_button = fruit_button;
        in_item.estop_level  = estop_level;
        in_item.estop_fell   = estop_fell;
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms      <= DEBOUNCE_MS_RST;
            cfg_reg.ramp_interval_ms <= RAMP_INTERVAL_RST;
            cfg_reg.angle_green      <= ANGLE_GREEN_RST;
            cfg_reg.angle_ripe       <= ANGLE_RIPE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DEBOUNCE_MS:   cfg_reg.debounce_ms      <= cfg_data[DEB_MS_W-1:0];
                CFG_RAMP_INTERVAL: cfg_reg.ramp_interval_ms <= cfg_data[7:0];
                CFG_ANGLE_GREEN:   cfg_reg.angle_green      <= cfg_data[7:0];
                CFG_ANGLE_RIPE:    cfg_reg.angle_ripe       <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // Input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_item_reg <= in_item;
        end
    end

    crsc_pass #(
        .DUTY_BITS     (DUTY_BITS),
        .DEBOUNCE_BITS (DEBOUNCE_BITS)
    ) u_pass (
        .cfg              (cfg_reg),
        .item             (in_item_reg),
        .state            (state_reg),
        .duty             (duty_reg),
        .deb_elapsed      (deb_reg),
        .state_next       (state_next),
        .duty_next        (duty_next),
        .deb_elapsed_next (deb_next),
        .result           (result_next)
    );

    // Controller state and result valid advance together on each pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode             <= MODE_WAIT;
            state_reg.route_ripe       <= 1'b0;
            state_reg.prev_belt_level  <= 1'b1;
            state_reg.prev_fruit_level <= 1'b1;
            state_reg.ramp_elapsed     <= '0;
            duty_reg                   <= '0;
            deb_reg                    <= '0;
            out_valid_reg              <= 1'b0;
        end
        else if (pass_fire)
        begin
            state_reg     <= state_next;
            duty_reg      <= duty_next;
            deb_reg       <= deb_next;
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pass_fire)
        begin
            result_reg <= result_next;
        end
    end

    // The duty register only changes on a pass, so it is the reported duty.
    assign out_valid      = out_valid_reg;
    assign motor_duty     = duty_reg;
    assign servo_angle    = result_reg.servo_angle;
    assign belt_mode      = result_reg.belt_mode;
    assign command_event  = result_reg.command_event;
    assign ramp_event     = result_reg.ramp_event;
    assign estop_handled  = result_reg.estop_handled;
    assign button_command = result_reg.button_command;

endmodule

/* rtl/crsc_pass.sv */
// One control pass of the conveyor controller as combinational logic.
// Depends on crsc_pkg; instantiated by conveyor_ramp_sorter_control.
module crsc_pass
    import crsc_pkg::*;
#(
    parameter int DUTY_BITS     = 8,
    parameter int DEBOUNCE_BITS = 10
) (
    input  cfg_t                      cfg,
    input  in_item_t                  item,
    input  ctrl_state_t               state,
    input  logic [DUTY_BITS-1:0]      duty,
    input  logic [DEBOUNCE_BITS-1:0]  deb_elapsed,
    output ctrl_state_t               state_next,
    output logic [DUTY_BITS-1:0]      duty_next,
    output logic [DEBOUNCE_BITS-1:0]  deb_elapsed_next,
    output result_t                   result
);

    localparam int CMP_W = (DEBOUNCE_BITS > DEB_MS_W) ? DEBOUNCE_BITS : DEB_MS_W;
    localparam logic [DEBOUNCE_BITS-1:0] DEB_MAX  = '1;
    localparam logic [DUTY_BITS-1:0]     DUTY_MAX = '1;
    localparam logic [RAMP_W-1:0]        RAMP_MAX = '1;

    logic [DEBOUNCE_BITS-1:0] deb_cnt;
    logic [RAMP_W-1:0]        ramp_cnt;
    mode_t                    mode;
    logic [DUTY_BITS-1:0]     duty_val;
    logic                     route;
    logic                     prev_belt;
    logic                     prev_fruit;
    logic                     host_cmd;
    logic [7:0]               cmd_code;
    logic [2:0]               cev;
    logic [1:0]               rev;
    logic [2:0]               bcmd;

    always_comb
    begin
        deb_cnt    = deb_elapsed;
        ramp_cnt   = state.ramp_elapsed;
        mode       = state.mode;
        duty_val   = duty;
        route      = state.route_ripe;
        prev_belt  = state.prev_belt_level;
        prev_fruit = state.prev_fruit_level;
        host_cmd   = item.cmd_valid;
        cmd_code   = CMD_NONE;
        cev        = CEV_NONE;
        rev        = REV_NONE;
        bcmd       = BCMD_NONE;

        // Both millisecond counters saturate.
        if (item.ms_tick)
        begin
            if (deb_cnt != DEB_MAX)
            begin
                deb_cnt = deb_cnt + 1'b1;
            end
            if (ramp_cnt != RAMP_MAX)
            begin
                ramp_cnt = ramp_cnt + 1'b1;
            end
        end

        // An emergency edge resets the belt and drops any host byte.
        if (item.estop_fell)
        begin
            duty_val = '0;
            mode     = MODE_WAIT;
            route    = 1'b0;
            host_cmd = 1'b0;
        end

        if (host_cmd)
        begin
            cmd_code = item.cmd_byte;
        end
        else
        begin
            if (CMP_W'(deb_cnt) > CMP_W'(cfg.debounce_ms))
            begin
                if (!item.belt_button && prev_belt)
                begin
                    if (mode == MODE_WAIT || mode == MODE_BRAKE)
                    begin
                        cmd_code = CMD_START;
                        bcmd     = BCMD_START;
                    end
                    else
                    begin
                        cmd_code = CMD_BRAKE;
                        bcmd     = BCMD_BRAKE;
                    end
                    deb_cnt = '0;
                end
                else if (!item.fruit_button && prev_fruit)
                begin
                    if (!route)
                    begin
                        cmd_code = CMD_RIPE;
                        bcmd     = BCMD_RIPE;
                    end
                    else
                    begin
                        cmd_code = CMD_GREEN;
                        bcmd     = BCMD_GREEN;
                    end
                    deb_cnt = '0;
                end
            end
            prev_belt  = item.belt_button;
            prev_fruit = item.fruit_button;
        end

        // Apply the command; a zero or unknown byte matches nothing.
        if (cmd_code == CMD_STOP)
        begin
            mode     = MODE_WAIT;
            duty_val = '0;
            route    = 1'b0;
            cev      = CEV_SOFT_STOP;
        end
        else if (mode == MODE_WAIT && cmd_code == CMD_START)
        begin
            if (!item.estop_level)
            begin
                cev = CEV_BLOCKED;
            end
            else
            begin
                mode = MODE_ACCEL;
                cev  = CEV_STARTING;
            end
        end
        else if (mode == MODE_OPER && cmd_code == CMD_BRAKE)
        begin
            mode = MODE_BRAKE;
            cev  = CEV_BRAKING;
        end
        else if (mode == MODE_OPER)
        begin
            if (cmd_code == CMD_RIPE && !route)
            begin
                route = 1'b1;
                cev   = CEV_RIPE;
            end
            else if (cmd_code == CMD_GREEN && route)
            begin
                route = 1'b0;
                cev   = CEV_GREEN;
            end
        end

        // Duty ramp, one step per elapsed interval.
        if (ramp_cnt > {1'b0, cfg.ramp_interval_ms})
        begin
            ramp_cnt = '0;
            case (mode)
                MODE_ACCEL:
                begin
                    if (duty_val != DUTY_MAX)
                    begin
                        duty_val = duty_val + 1'b1;
                    end
                    else
                    begin
                        mode = MODE_OPER;
                        rev  = REV_FULL;
                    end
                end
                MODE_BRAKE:
                begin
                    if (duty_val != '0)
                    begin
                        duty_val = duty_val - 1'b1;
                    end
                    else
                    begin
                        mode = MODE_WAIT;
                        rev  = REV_STOPPED;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next.mode             = mode;
        state_next.route_ripe       = route;
        state_next.prev_belt_level  = prev_belt;
        state_next.prev_fruit_level = prev_fruit;
        state_next.ramp_elapsed     = ramp_cnt;
        duty_next                   = duty_val;
        deb_elapsed_next            = deb_cnt;
        result.servo_angle          = route ? cfg.angle_ripe : cfg.angle_green;
        result.belt_mode            = mode_code(mode);
        result.command_event        = cev;
        result.ramp_event           = rev;
        result.estop_handled        = item.estop_fell;
        result.button_command       = bcmd;
    end

endmodule
